>>> rtl/cts_pkg.sv
// ----------------------------------------------------------------------------
// cts_pkg
// Shared types and constants of the cooperative task scheduler: opcodes,
// result kinds, the slot record and the slot update bundle.
// ----------------------------------------------------------------------------
package cts_pkg;

	typedef enum logic [1:0] {
		OP_ADD      = 2'd0,
		OP_TICK     = 2'd1,
		OP_DISPATCH = 2'd2,
		OP_DELETE   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		KIND_ADDED   = 3'd0,
		KIND_FULL    = 3'd1,
		KIND_DELETED = 3'd2,
		KIND_TICK    = 3'd3,
		KIND_RUN     = 3'd4,
		KIND_IDLE    = 3'd5
	} kind_t;

	// most runs handed out by one dispatch
	localparam int RESULT_LIMIT = 8;
	localparam int RUN_CW       = $clog2(RESULT_LIMIT);

	localparam logic [7:0] PENDING_MAX = 8'hFF;

	typedef struct packed {
		logic [7:0]  tag;
		logic [15:0] delay;
		logic [15:0] period;
		logic [7:0]  pending;
	} slot_rec_t;

	typedef struct packed {
		slot_rec_t next;
		logic      wr;
		logic      hit;
	} slot_upd_t;

endpackage

>>> rtl/cts_slot_table.sv
// ----------------------------------------------------------------------------
// cts_slot_table
// Task slot register file, one combined read/write address, cleared at reset.
// ----------------------------------------------------------------------------
module cts_slot_table #(
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [AW-1:0]     addr,
	input  logic              wr_en,
	input  cts_pkg::slot_rec_t wr_data,
	output cts_pkg::slot_rec_t rd_data
);

	cts_pkg::slot_rec_t slots_q [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				slots_q[i] <= '0;
			end
		end else if (wr_en) begin
			slots_q[addr] <= wr_data;
		end
	end

	assign rd_data = slots_q[addr];

endmodule

>>> rtl/cts_slot_alu.sv
// ----------------------------------------------------------------------------
// cts_slot_alu
// Shared slot update unit: works out the new contents of one slot for the
// current operation and flags whether the slot is a hit.
// ----------------------------------------------------------------------------
module cts_slot_alu (
	input  cts_pkg::op_t       op,
	input  cts_pkg::slot_rec_t rec,
	input  logic [7:0]         add_tag,
	input  logic [15:0]        add_delay,
	input  logic [15:0]        add_period,
	output cts_pkg::slot_upd_t upd
);

	always_comb begin
		upd.next = rec;
		upd.wr   = 1'b0;
		upd.hit  = 1'b0;
		unique case (op)
			cts_pkg::OP_ADD: begin
				// a free slot takes the new task
				upd.hit          = (rec.tag == 8'd0);
				upd.wr           = upd.hit;
				upd.next.tag     = add_tag;
				upd.next.delay   = add_delay;
				upd.next.period  = add_period;
				upd.next.pending = 8'd0;
			end
			cts_pkg::OP_TICK: begin
				upd.wr = (rec.tag != 8'd0);
				if (rec.delay == 16'd0) begin
					if (rec.pending != cts_pkg::PENDING_MAX) begin
						upd.next.pending = rec.pending + 8'd1;
					end
					if (rec.period != 16'd0) begin
						upd.next.delay = rec.period;
					end
				end else begin
					upd.next.delay = rec.delay - 16'd1;
				end
			end
			cts_pkg::OP_DISPATCH: begin
				upd.hit          = (rec.pending != 8'd0);
				upd.wr           = upd.hit;
				upd.next.pending = rec.pending - 8'd1;
				// one-shot tasks leave the table after their run
				if (rec.period == 16'd0) begin
					upd.next = '0;
				end
			end
			cts_pkg::OP_DELETE: begin
				upd.wr   = 1'b1;
				upd.next = '0;
			end
			default: begin
				upd.wr = 1'b0;
			end
		endcase
	end

endmodule

>>> rtl/cooperative_task_scheduler_unit.sv
// ----------------------------------------------------------------------------
// cooperative_task_scheduler_unit
// Time-triggered task table with add, tick, dispatch and delete commands.
// ----------------------------------------------------------------------------
// One command is taken at a time; in_stall stays high until it has been
// worked through. A single slot update unit visits one slot per cycle
// unless a result is held up by out_stall. Add scans from slot 0 up to
// the first free slot (at most MAX_TASKS slots), tick visits every slot,
// dispatch scans until its eighth run or the last slot and then hands out
// its final result, and delete works on the named slot only. Dispatch
// gives up to eight run results, lowest slot first; every other command
// gives one result. The last result of a command has last set.
module cooperative_task_scheduler_unit #(
	parameter int MAX_TASKS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [7:0]  task_tag,
	input  logic [15:0] first_delay,
	input  logic [15:0] repeat_period,
	input  logic [2:0]  slot_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [2:0]  slot,
	output logic [7:0]  run_tag,
	output logic        error_latched,
	output logic        last
);

	localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam logic [IW-1:0] LAST_SLOT = IW'(MAX_TASKS - 1);
	localparam logic [4:0] SLOT_COUNT = 5'(MAX_TASKS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	state_t                  state_q;
	cts_pkg::op_t            op_q;
	logic [7:0]              tag_q;
	logic [15:0]             delay_q;
	logic [15:0]             period_q;
	logic [2:0]              idx_q;
	logic [IW-1:0]           scan_q;
	logic [cts_pkg::RUN_CW-1:0] run_cnt_q;
	logic                    staged_v_q;
	logic [2:0]              staged_slot_q;
	logic [7:0]              staged_tag_q;
	logic                    full_error_q;

	logic                    out_valid_q;
	cts_pkg::kind_t          out_kind_q;
	logic [2:0]              out_slot_q;
	logic [7:0]              out_tag_q;
	logic                    out_err_q;
	logic                    out_last_q;

	logic [IW-1:0]           tbl_addr;
	logic                    tbl_wr;
	cts_pkg::slot_rec_t      tbl_rd;
	cts_pkg::slot_upd_t      upd;

	logic                    idx_in_range;
	logic                    scan_last;
	logic                    run_full;
	logic                    out_free;
	logic                    need_emit;
	logic                    adv;
	logic                    emit_fire;
	cts_pkg::kind_t          e_kind;
	logic [2:0]              e_slot;
	logic [7:0]              e_tag;
	logic                    e_err;
	logic                    e_last;

	cts_slot_table #(
		.DEPTH (MAX_TASKS),
		.AW    (IW)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.addr    (tbl_addr),
		.wr_en   (tbl_wr),
		.wr_data (upd.next),
		.rd_data (tbl_rd)
	);

	cts_slot_alu u_alu (
		.op         (op_q),
		.rec        (tbl_rd),
		.add_tag    (tag_q),
		.add_delay  (delay_q),
		.add_period (period_q),
		.upd        (upd)
	);

	assign idx_in_range = ({2'b00, idx_q} < SLOT_COUNT);
	assign tbl_addr     = (op_q == cts_pkg::OP_DELETE) ? IW'(idx_q) : scan_q;
	assign scan_last    = (scan_q == LAST_SLOT);
	assign run_full     = (run_cnt_q == cts_pkg::RUN_CW'(cts_pkg::RESULT_LIMIT - 1));
	assign out_free     = !out_valid_q || !out_stall;

	// result selection for the current step
	always_comb begin
		need_emit = 1'b0;
		e_kind    = cts_pkg::KIND_TICK;
		e_slot    = 3'd0;
		e_tag     = 8'd0;
		e_err     = full_error_q;
		e_last    = 1'b1;
		unique case (state_q)
			ST_SCAN: begin
				unique case (op_q)
					cts_pkg::OP_ADD: begin
						if (upd.hit) begin
							need_emit = 1'b1;
							e_kind    = cts_pkg::KIND_ADDED;
							e_slot    = 3'(scan_q);
						end else if (scan_last) begin
							need_emit = 1'b1;
							e_kind    = cts_pkg::KIND_FULL;
							e_err     = 1'b1;
						end
					end
					cts_pkg::OP_TICK: begin
						need_emit = scan_last;
						e_kind    = cts_pkg::KIND_TICK;
					end
					cts_pkg::OP_DISPATCH: begin
						// a new run pushes out the one held back
						need_emit = upd.hit && staged_v_q;
						e_kind    = cts_pkg::KIND_RUN;
						e_slot    = staged_slot_q;
						e_tag     = staged_tag_q;
						e_last    = 1'b0;
					end
					cts_pkg::OP_DELETE: begin
						need_emit = 1'b1;
						e_kind    = cts_pkg::KIND_DELETED;
						e_slot    = idx_q;
					end
					default: begin
						need_emit = 1'b0;
					end
				endcase
			end
			ST_FLUSH: begin
				need_emit = 1'b1;
				if (staged_v_q) begin
					e_kind = cts_pkg::KIND_RUN;
					e_slot = staged_slot_q;
					e_tag  = staged_tag_q;
				end else begin
					e_kind = cts_pkg::KIND_IDLE;
				end
			end
			default: begin
				need_emit = 1'b0;
			end
		endcase
	end

	assign adv       = !need_emit || out_free;
	assign emit_fire = need_emit && out_free;
	assign tbl_wr    = (state_q == ST_SCAN) && adv && upd.wr
		&& ((op_q != cts_pkg::OP_DELETE) || idx_in_range);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			scan_q       <= '0;
			run_cnt_q    <= '0;
			staged_v_q   <= 1'b0;
			full_error_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q    <= ST_SCAN;
						scan_q     <= '0;
						run_cnt_q  <= '0;
						staged_v_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (adv) begin
						unique case (op_q)
							cts_pkg::OP_ADD: begin
								if (upd.hit) begin
									state_q <= ST_IDLE;
								end else if (scan_last) begin
									state_q      <= ST_IDLE;
									full_error_q <= 1'b1;
								end else begin
									scan_q <= scan_q + 1'b1;
								end
							end
							cts_pkg::OP_TICK: begin
								if (scan_last) begin
									state_q <= ST_IDLE;
								end else begin
									scan_q <= scan_q + 1'b1;
								end
							end
							cts_pkg::OP_DISPATCH: begin
								if (upd.hit) begin
									staged_v_q <= 1'b1;
									run_cnt_q  <= run_cnt_q + 1'b1;
								end
								if ((upd.hit && run_full) || scan_last) begin
									state_q <= ST_FLUSH;
								end else begin
									scan_q <= scan_q + 1'b1;
								end
							end
							cts_pkg::OP_DELETE: begin
								state_q <= ST_IDLE;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_FLUSH: begin
					if (adv) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// command fields and the held-back run
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			op_q     <= cts_pkg::op_t'(opcode);
			tag_q    <= task_tag;
			delay_q  <= first_delay;
			period_q <= repeat_period;
			idx_q    <= slot_index;
		end
		if (state_q == ST_SCAN && op_q == cts_pkg::OP_DISPATCH && adv && upd.hit) begin
			staged_slot_q <= 3'(scan_q);
			staged_tag_q  <= tbl_rd.tag;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_kind_q <= e_kind;
			out_slot_q <= e_slot;
			out_tag_q  <= e_tag;
			out_err_q  <= e_err;
			out_last_q <= e_last;
		end
	end

	assign in_stall      = (state_q != ST_IDLE);
	assign out_valid     = out_valid_q;
	assign kind          = out_kind_q;
	assign slot          = out_slot_q;
	assign run_tag       = out_tag_q;
	assign error_latched = out_err_q;
	assign last          = out_last_q;

endmodule

>>> rtl/cts_checker.sv
// ----------------------------------------------------------------------------
// cts_checker
// Port-level checks of the task scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module cts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  kind,
	input logic [2:0]  slot,
	input logic [7:0]  run_tag,
	input logic        error_latched,
	input logic        last
);

	// a stalled result holds still
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(slot)
			&& $stable(run_tag) && $stable(error_latched) && $stable(last))
		else $error("stalled result changed");

	// one command at a time: a transfer in closes the input
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input open right after a transfer");

	a_tag_only_on_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind != cts_pkg::KIND_RUN) |-> run_tag == 8'd0)
		else $error("run tag on a result that runs nothing");

	// a full table latches the error at once
	a_full_sets_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == cts_pkg::KIND_FULL) |-> error_latched && last)
		else $error("table full without error flag");

	// the error flag never falls once seen
	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_latched && !out_stall ##1 out_valid |-> error_latched)
		else $error("error flag cleared");

endmodule

bind cooperative_task_scheduler_unit cts_checker u_cts_checker (.*);
